// ===== src/pbrs_pkg.sv =====
// Package for the parameter block ring scanner: constants, types and helpers.
`timescale 1ns / 1ps

package pbrs_pkg;

    // Parameter defaults
    localparam int DEF_MAX_BLOCK_BYTES = 1024;
    localparam int DEF_MAX_SLOTS       = 64;

    // Register widths and reset values
    localparam int BLOCK_SIZE_W = 11;
    localparam int SLOT_COUNT_W = 7;
    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = 11'd64;
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 7'd16;

    // Configuration address map (registers on 4-byte boundaries)
    localparam int  CFG_ADDR_W     = 3;
    localparam logic CFG_SEL_BLOCK_SIZE = 1'b0;
    localparam logic CFG_SEL_SLOT_COUNT = 1'b1;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int OSLOT_W  = 6;
    localparam int OUT_DATA_W = 40;
    localparam logic [7:0] SEQ_HALF = 8'd128;

    // Per-transaction control flags from the slot accumulator
    typedef struct packed {
        logic accept;
        logic restart;
        logic slot_end;
        logic valid;
        logic last;
    } t_slot_ev;

    // True when candidate sequence cand is not older than current cur
    function automatic logic seq_not_older(input logic [7:0] cur, input logic [7:0] cand);
        logic [7:0] diff_cc;
        logic [7:0] diff_nc;
        logic       older;
        diff_cc = cur - cand;
        diff_nc = cand - cur;
        older   = 1'b0;
        if ((cur > cand) && (diff_cc < SEQ_HALF)) begin
            older = 1'b1;
        end
        if ((cand > cur) && (diff_nc > SEQ_HALF)) begin
            older = 1'b1;
        end
        return !older;
    endfunction

endpackage

// ===== src/parameter_block_ring_scanner.sv =====
// Top level of the parameter block ring scanner.
//
// Usage: stream the bytes of the slot ring in address order on s_axis, one byte
// per transaction; set tuser on the first byte of a new scan to clear the
// selection. Byte 0 of each slot is its sequence number. At each slot end one
// transaction leaves on m_axis carrying the slot's index and validity, the
// most recent valid slot so far, and the next slot and sequence to write.
// tlast marks the result of the last slot in the ring.
// Output: a result is registered in the cycle after the slot's final byte is taken.
// Throughput: one byte per cycle unless a result waits unaccepted; the accumulate,
// compare and select path sits between the input handshake and the result register.
// Stall: while a result waits unaccepted, s_axis_tready follows
// m_axis_tready, so bytes keep flowing whenever the result is being taken.
// Reset: synchronous active-low; position, counters and selection clear,
// block_size returns to 64 and slot_count to 16. The APB port (pready always
// high) holds block_size at 0x0 and slot_count at 0x4; write only while idle.
`timescale 1ns / 1ps

module parameter_block_ring_scanner
    import pbrs_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int MAX_SLOTS       = DEF_MAX_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input bytes
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] scan_byte
    input  logic [0:0]            s_axis_tuser,   // [0] ring_restart
    // Slot results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [5:0] slot_index, [6] slot_valid, [7] found_any, [13:8] recent_slot,
    // [21:14] recent_sequence, [27:22] next_slot, [35:28] next_sequence, [39:36] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,   // scan_done
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SW  = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int SLW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [SW-1:0]     eff_size;
    logic [CW-1:0]     eff_count;
    logic              accept;
    t_slot_ev          slot_ev;
    logic [SLW-1:0]    slot_idx;
    logic [BYTE_W-1:0] first_byte;

    assign accept = s_axis_tvalid && s_axis_tready;

    pbrs_cfg #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .MAX_SLOTS       (MAX_SLOTS),
        .SW              (SW),
        .CW              (CW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_eff_size  (eff_size),
        .o_eff_count (eff_count)
    );

    pbrs_slot_acc #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .MAX_SLOTS       (MAX_SLOTS),
        .SW              (SW),
        .CW              (CW),
        .SLW             (SLW)
    ) u_slot_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_restart   (s_axis_tuser[0]),
        .i_eff_size  (eff_size),
        .i_eff_count (eff_count),
        .o_ev        (slot_ev),
        .o_slot      (slot_idx),
        .o_first     (first_byte)
    );

    pbrs_select #(
        .MAX_SLOTS (MAX_SLOTS),
        .CW        (CW),
        .SLW       (SLW)
    ) u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev        (slot_ev),
        .i_slot      (slot_idx),
        .i_first     (first_byte),
        .i_eff_count (eff_count),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// ===== src/pbrs_cfg.sv =====
// Configuration registers with APB-style access and clamped effective values.
`timescale 1ns / 1ps

module pbrs_cfg
    import pbrs_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int MAX_SLOTS       = DEF_MAX_SLOTS,
    parameter int SW = $clog2(MAX_BLOCK_BYTES + 1),
    parameter int CW = $clog2(MAX_SLOTS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [SW-1:0]         o_eff_size,
    output logic [CW-1:0]         o_eff_count
);

    logic [BLOCK_SIZE_W-1:0] r_block_size;
    logic [SLOT_COUNT_W-1:0] r_slot_count;
    logic                    wr_en;
    logic [31:0]             size_w;
    logic [31:0]             count_w;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes; the word address picks the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BLOCK_SIZE_RST;
            r_slot_count <= SLOT_COUNT_RST;
        end else if (wr_en) begin
            if (paddr[2] == CFG_SEL_BLOCK_SIZE) begin
                r_block_size <= pwdata[BLOCK_SIZE_W-1:0];
            end else begin
                r_slot_count <= pwdata[SLOT_COUNT_W-1:0];
            end
        end
    end

    // Read-back
    always_comb begin
        if (paddr[2] == CFG_SEL_BLOCK_SIZE) begin
            prdata = 32'(r_block_size);
        end else begin
            prdata = 32'(r_slot_count);
        end
    end

    // Clamp to the supported ranges
    always_comb begin
        size_w  = 32'(r_block_size);
        count_w = 32'(r_slot_count);
        if (size_w < 32'd2) size_w = 32'd2;
        if (size_w > 32'(MAX_BLOCK_BYTES)) size_w = 32'(MAX_BLOCK_BYTES);
        if (count_w < 32'd1) count_w = 32'd1;
        if (count_w > 32'(MAX_SLOTS)) count_w = 32'(MAX_SLOTS);
    end

    assign o_eff_size  = size_w[SW-1:0];
    assign o_eff_count = count_w[CW-1:0];

endmodule

// ===== src/pbrs_slot_acc.sv =====
// Slot accumulator: byte position, slot counter, checksum and slot validity.
`timescale 1ns / 1ps

module pbrs_slot_acc
    import pbrs_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int MAX_SLOTS       = DEF_MAX_SLOTS,
    parameter int SW  = $clog2(MAX_BLOCK_BYTES + 1),
    parameter int CW  = $clog2(MAX_SLOTS + 1),
    parameter int SLW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_restart,
    input  logic [SW-1:0]     i_eff_size,
    input  logic [CW-1:0]     i_eff_count,
    output t_slot_ev          o_ev,
    output logic [SLW-1:0]    o_slot,
    output logic [BYTE_W-1:0] o_first
);

    localparam int PW   = (MAX_BLOCK_BYTES > 2) ? $clog2(MAX_BLOCK_BYTES) : 1;
    localparam int SUMW = $clog2(MAX_BLOCK_BYTES * 255 + 1);

    logic [PW-1:0]     r_pos,   n_pos;
    logic [SLW-1:0]    r_slot,  n_slot;
    logic [SUMW-1:0]   r_sum,   n_sum;
    logic [BYTE_W-1:0] r_first, n_first;

    logic [PW-1:0]     pos_cur;
    logic [SLW-1:0]    slot_cur;
    logic [SUMW-1:0]   sum_new;
    logic [SW+7:0]     erased_sum;
    logic              slot_end;
    logic              last;
    logic              valid;

    // Restart folds into the current position and counter
    always_comb begin
        pos_cur  = i_restart ? '0 : r_pos;
        slot_cur = i_restart ? '0 : r_slot;
        n_first  = (pos_cur == '0) ? i_byte : r_first;
        sum_new  = ((pos_cur == '0) ? '0 : r_sum) + SUMW'(i_byte);
        slot_end = ((SW+1)'(pos_cur) + (SW+1)'(1)) >= (SW+1)'(i_eff_size);
        last     = ((CW+1)'(slot_cur) + (CW+1)'(1)) >= (CW+1)'(i_eff_count);
        // An erased slot sums to size * 0xff
        erased_sum = {i_eff_size, 8'h00} - (SW+8)'(i_eff_size);
        valid    = (sum_new[7:0] == 8'h00) && ((SW+8)'(sum_new) != erased_sum);
    end

    // Next state
    always_comb begin
        if (slot_end) begin
            n_pos  = '0;
            n_sum  = '0;
            n_slot = last ? '0 : slot_cur + SLW'(1);
        end else begin
            n_pos  = pos_cur + PW'(1);
            n_sum  = sum_new;
            n_slot = slot_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_slot <= '0;
            r_sum  <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_slot <= n_slot;
            r_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
        end else if (i_accept) begin
            r_first <= n_first;
        end
    end

    assign o_ev.accept   = i_accept;
    assign o_ev.restart  = i_restart;
    assign o_ev.slot_end = slot_end;
    assign o_ev.valid    = valid;
    assign o_ev.last     = last;
    assign o_slot        = slot_cur;
    assign o_first       = n_first;

endmodule

// ===== src/pbrs_select.sv =====
// Most-recent-slot selection and the registered result stage.
`timescale 1ns / 1ps

module pbrs_select
    import pbrs_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int CW  = $clog2(MAX_SLOTS + 1),
    parameter int SLW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_slot_ev              i_ev,
    input  logic [SLW-1:0]        i_slot,
    input  logic [BYTE_W-1:0]     i_first,
    input  logic [CW-1:0]         i_eff_count,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_last
);

    logic              r_have,     n_have;
    logic [SLW-1:0]    r_best,     n_best;
    logic [BYTE_W-1:0] r_best_seq, n_best_seq;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                  r_out_last;

    logic              have_cur;
    logic [SLW-1:0]    best_cur;
    logic [BYTE_W-1:0] seq_cur;
    logic              take;
    logic [SLW-1:0]    next_slot;
    logic [BYTE_W-1:0] next_seq;

    // Selection update; restart drops the previous choice
    always_comb begin
        have_cur   = i_ev.restart ? 1'b0 : r_have;
        best_cur   = i_ev.restart ? '0   : r_best;
        seq_cur    = i_ev.restart ? '0   : r_best_seq;
        take       = i_ev.slot_end && i_ev.valid &&
                     (!have_cur || seq_not_older(seq_cur, i_first));
        n_have     = have_cur || take;
        n_best     = take ? i_slot  : best_cur;
        n_best_seq = take ? i_first : seq_cur;
    end

    // Next write location, zeros when nothing was found
    always_comb begin
        if (n_have) begin
            if (((CW+1)'(n_best) + (CW+1)'(1)) >= (CW+1)'(i_eff_count)) begin
                next_slot = '0;
            end else begin
                next_slot = n_best + SLW'(1);
            end
            next_seq = n_best_seq + 8'd1;
        end else begin
            next_slot = '0;
            next_seq  = '0;
        end
        n_out_data = {4'h0,
                      next_seq,
                      OSLOT_W'(next_slot),
                      n_have ? n_best_seq : 8'h00,
                      n_have ? OSLOT_W'(n_best) : OSLOT_W'(0),
                      n_have,
                      i_ev.valid,
                      OSLOT_W'(i_slot)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_best     <= '0;
            r_best_seq <= '0;
        end else if (i_ev.accept) begin
            r_have     <= n_have;
            r_best     <= n_best;
            r_best_seq <= n_best_seq;
        end
    end

    // Result register: loads at a slot end, clears when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ev.accept && i_ev.slot_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ev.accept && i_ev.slot_end) begin
            r_out_data <= n_out_data;
            r_out_last <= i_ev.last;
        end
    end

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule
